// ===== rtl/i2ctb_pkg.sv =====
// Shared types and constants for the I2C target bit-level state machine.
`timescale 1ns / 1ps

package i2ctb_pkg;

    localparam int unsigned PhaseW = 3;

    localparam logic [PhaseW-1:0] PH_IDLE     = 3'd0;
    localparam logic [PhaseW-1:0] PH_HEADER   = 3'd1;
    localparam logic [PhaseW-1:0] PH_ACK_HDR  = 3'd2;
    localparam logic [PhaseW-1:0] PH_RX       = 3'd3;
    localparam logic [PhaseW-1:0] PH_ACK_RX   = 3'd4;
    localparam logic [PhaseW-1:0] PH_TX       = 3'd5;
    localparam logic [PhaseW-1:0] PH_WAIT_ACK = 3'd6;

    localparam logic       CFG_FIRST_READ_BYTE = 1'b0;
    localparam logic       CFG_NEXT_READ_BYTE  = 1'b1;
    localparam logic [7:0] FIRST_READ_RESET    = 8'h81;
    localparam logic [7:0] NEXT_READ_RESET     = 8'h85;
    localparam logic [2:0] BITS_LAST           = 3'd7;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
    } sample_t;

    typedef struct packed {
        logic       sda_out;
        logic       sda_drive;
        logic [6:0] target_address;
        logic       read_request;
        logic [7:0] last_rx_byte;
    } result_t;

    typedef struct packed {
        logic [7:0] first_read_byte;
        logic [7:0] next_read_byte;
    } cfg_t;

endpackage

// ===== rtl/i2ctb_cfg.sv =====
// Configuration registers holding the bytes sent in read transfers.
`timescale 1ns / 1ps

module i2ctb_cfg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_wdata,
    output i2ctb_pkg::cfg_t  cfg
);

    i2ctb_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_read_byte <= i2ctb_pkg::FIRST_READ_RESET;
            cfg_reg.next_read_byte  <= i2ctb_pkg::NEXT_READ_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                i2ctb_pkg::CFG_FIRST_READ_BYTE: cfg_reg.first_read_byte <= cfg_wdata;
                i2ctb_pkg::CFG_NEXT_READ_BYTE:  cfg_reg.next_read_byte  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/i2ctb_core.sv =====
// Bit-level protocol state machine: one pin sample is processed per step.
`timescale 1ns / 1ps

module i2ctb_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  i2ctb_pkg::sample_t  sample,
    input  i2ctb_pkg::cfg_t     cfg,
    output i2ctb_pkg::result_t  result
);

    logic                         sda_prev_reg, scl_prev_reg;
    logic                         start_seen_reg, stop_seen_reg;
    logic [i2ctb_pkg::PhaseW-1:0] phase_reg, phase_next;
    logic [6:0]                   addr_reg, addr_next;
    logic                         read_flag_reg, read_flag_next;
    logic [7:0]                   rx_data_reg, rx_data_next;
    logic                         drive_flag_reg, drive_flag_next;
    logic [8:0]                   tx_shift_reg, tx_shift_next;
    logic [7:0]                   rx_shift_reg, rx_shift_next;
    logic [2:0]                   bit_count_reg, bit_count_next;
    logic                         rise;

    // The result reflects the state before this sample is applied.
    assign result.sda_out        = tx_shift_reg[8];
    assign result.sda_drive      = drive_flag_reg;
    assign result.target_address = addr_reg;
    assign result.read_request   = read_flag_reg;
    assign result.last_rx_byte   = rx_data_reg;

    assign rise = !scl_prev_reg && sample.scl_level;

    always_comb begin
        phase_next      = phase_reg;
        addr_next       = addr_reg;
        read_flag_next  = read_flag_reg;
        rx_data_next    = rx_data_reg;
        drive_flag_next = drive_flag_reg;
        tx_shift_next   = tx_shift_reg;
        bit_count_next  = bit_count_reg;
        rx_shift_next   = rise ? {rx_shift_reg[6:0], sample.sda_level} : rx_shift_reg;

        case (phase_reg)
            i2ctb_pkg::PH_IDLE: begin
                tx_shift_next   = '0;
                addr_next       = '0;
                read_flag_next  = 1'b0;
                rx_data_next    = '0;
                drive_flag_next = 1'b0;
                if (start_seen_reg) begin
                    bit_count_next = i2ctb_pkg::BITS_LAST;
                    phase_next     = i2ctb_pkg::PH_HEADER;
                end
            end
            i2ctb_pkg::PH_HEADER, i2ctb_pkg::PH_RX: begin
                if (rise) begin
                    if (bit_count_reg == 3'd0) begin
                        drive_flag_next = 1'b1;
                        phase_next = (phase_reg == i2ctb_pkg::PH_HEADER) ?
                                     i2ctb_pkg::PH_ACK_HDR : i2ctb_pkg::PH_ACK_RX;
                    end else begin
                        bit_count_next = bit_count_reg - 3'd1;
                    end
                end
            end
            i2ctb_pkg::PH_ACK_HDR: begin
                if (rise) begin
                    addr_next      = rx_shift_reg[7:1];
                    read_flag_next = rx_shift_reg[0];
                    bit_count_next = i2ctb_pkg::BITS_LAST;
                    if (!rx_shift_reg[0]) begin
                        drive_flag_next = 1'b0;
                        phase_next      = i2ctb_pkg::PH_RX;
                    end else begin
                        phase_next    = i2ctb_pkg::PH_TX;
                        tx_shift_next = {1'b0, cfg.first_read_byte};
                    end
                end
            end
            i2ctb_pkg::PH_ACK_RX: begin
                if (rise) begin
                    rx_data_next = rx_shift_reg;
                    if (sample.sda_level) begin
                        phase_next = i2ctb_pkg::PH_IDLE;
                    end else begin
                        bit_count_next  = i2ctb_pkg::BITS_LAST;
                        drive_flag_next = 1'b0;
                        phase_next      = i2ctb_pkg::PH_RX;
                    end
                end
            end
            i2ctb_pkg::PH_TX: begin
                if (rise) begin
                    tx_shift_next = {tx_shift_reg[7:0], 1'b0};
                    if (bit_count_reg == 3'd0) begin
                        drive_flag_next = 1'b0;
                        phase_next      = i2ctb_pkg::PH_WAIT_ACK;
                    end else begin
                        bit_count_next = bit_count_reg - 3'd1;
                    end
                end
            end
            i2ctb_pkg::PH_WAIT_ACK: begin
                if (rise) begin
                    drive_flag_next = 1'b1;
                    if (sample.sda_level) begin
                        phase_next = i2ctb_pkg::PH_IDLE;
                    end else begin
                        bit_count_next = i2ctb_pkg::BITS_LAST;
                        tx_shift_next  = {1'b0, cfg.next_read_byte};
                        phase_next     = i2ctb_pkg::PH_TX;
                    end
                end
            end
            default: begin
                phase_next = i2ctb_pkg::PH_IDLE;
            end
        endcase

        // A stop anywhere but idle ends the transfer.
        if (phase_reg != i2ctb_pkg::PH_IDLE && stop_seen_reg) begin
            phase_next = i2ctb_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sda_prev_reg   <= 1'b0;
            scl_prev_reg   <= 1'b0;
            start_seen_reg <= 1'b0;
            stop_seen_reg  <= 1'b0;
            phase_reg      <= i2ctb_pkg::PH_IDLE;
            addr_reg       <= '0;
            read_flag_reg  <= 1'b0;
            rx_data_reg    <= '0;
            drive_flag_reg <= 1'b0;
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            bit_count_reg  <= '0;
        end else if (step) begin
            start_seen_reg <= sda_prev_reg && !sample.sda_level && sample.scl_level;
            stop_seen_reg  <= !sda_prev_reg && sample.sda_level && sample.scl_level;
            sda_prev_reg   <= sample.sda_level;
            scl_prev_reg   <= sample.scl_level;
            phase_reg      <= phase_next;
            addr_reg       <= addr_next;
            read_flag_reg  <= read_flag_next;
            rx_data_reg    <= rx_data_next;
            drive_flag_reg <= drive_flag_next;
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            bit_count_reg  <= bit_count_next;
        end
    end

endmodule

// ===== rtl/i2c_target_bit_fsm.sv =====
// Top level of the oversampled I2C target: sample and result registers around the core.
`timescale 1ns / 1ps
//
// Usage
//   The s_ channel carries one beat per system-clock sample of the SCL and
//   SDA pins. Each accepted beat yields exactly one m_ beat that shows the
//   target's outputs (SDA level and drive enable, captured address, R/W bit,
//   last received byte) as they stood before that sample was applied.
//   Each beat passes through the sample register and then the result
//   register on its way to m_valid. Throughput is one beat per cycle while
//   m_ready is high, set by the state update between the two registers.
//   When m_ready is low, the result register holds its beat, the sample
//   register fills, and s_ready drops; no beat is lost or repeated.
//   The cfg_ port writes the first or the next read byte, chosen by
//   cfg_index; write it only while no beat is in flight.
//   Reset (aresetn low, synchronous) empties both registers, returns the
//   state machine to idle with SDA released, and restores the read bytes
//   to 0x81 and 0x85.
//
module i2c_target_bit_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2ctb_pkg::sample_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output i2ctb_pkg::result_t  m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata
);

    logic                in_valid_reg;
    i2ctb_pkg::sample_t  in_data_reg;
    logic                out_valid_reg;
    i2ctb_pkg::result_t  out_data_reg;
    i2ctb_pkg::result_t  core_result;
    i2ctb_pkg::cfg_t     cfg;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    i2ctb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    i2ctb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .sample  (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
